[hdl/uss_pkg.sv]
// ----------------------------------------------------------------------------
// uss_pkg - shared types and constants for the URL span scanner
// Byte class flags, result record and sizing defaults.
// ----------------------------------------------------------------------------
package uss_pkg;

    localparam int MAX_LINE_BYTES_DEF = 4096;
    localparam int OUT_W              = 13;   // width of the offset result fields

    // class of one text byte, C locale
    typedef struct packed {
        logic is_letter;
        logic is_url;
        logic is_colon;
        logic is_slash;
    } t_byte_class;

    // one result record from the scan core
    typedef struct packed {
        logic             emit;
        logic [OUT_W-1:0] url_start;
        logic [OUT_W-1:0] url_stop;
        logic             offset_saturated;
    } t_result;

endpackage

[hdl/url_span_scanner_top.sv]
// ----------------------------------------------------------------------------
// url_span_scanner_top - URL span scanner, one byte per cycle unless stalled
// Finds scheme://... URLs in a byte stream and reports their offsets.
// ----------------------------------------------------------------------------
// Feed one line a byte per request, with i_line_end on its last byte; the
// scanner then forgets everything and the next byte is offset 0 of a new
// line. A URL is a run of ASCII letters directly before "://" followed by
// at least one URL byte; it ends at the first non-URL byte or at the line
// end. One result request goes out per URL, when it closes, carrying the
// offset of the first scheme letter and the offset just past the last URL
// byte. Offsets stick at MAX_LINE_BYTES on long lines and
// o_offset_saturated flags it; the result fields are 13 bits wide, so a
// MAX_LINE_BYTES above 8191 wraps there. Rate: one byte per cycle while
// the receiver does not stall the result. The pace is set by the update
// of the scan state, which sits between the input register and the
// result register. A pending result that the receiver stalls only holds
// up the input once the input register is full.
// ----------------------------------------------------------------------------
module url_span_scanner_top #(
    parameter int MAX_LINE_BYTES = uss_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte requests
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_line_end,
    // result requests
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [uss_pkg::OUT_W-1:0] o_url_start,
    output logic [uss_pkg::OUT_W-1:0] o_url_stop,
    output logic                      o_offset_saturated
);
    import uss_pkg::*;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_text_byte;
    logic       r_line_end;

    // result register
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_url_start;
    logic [OUT_W-1:0] r_url_stop;
    logic             r_saturated;

    logic        load;      // request taken into the input register
    logic        advance;   // held byte goes through the scan core
    t_byte_class byte_class;
    t_result     result;

    // the held byte moves on whenever the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (load) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance && result.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    uss_byte_class u_class (
        .i_text_byte (r_text_byte),
        .o_class     (byte_class)
    );

    uss_scan_core #(
        .MaxLineBytes (MAX_LINE_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_line_end (r_line_end),
        .i_class    (byte_class),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        if (load) begin
            r_text_byte <= i_text_byte;
            r_line_end  <= i_line_end;
        end
        if (advance && result.emit) begin
            r_url_start <= result.url_start;
            r_url_stop  <= result.url_stop;
            r_saturated <= result.offset_saturated;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_url_start        = r_url_start;
    assign o_url_stop         = r_url_stop;
    assign o_offset_saturated = r_saturated;

endmodule

[hdl/uss_byte_class.sv]
// ----------------------------------------------------------------------------
// uss_byte_class - text byte classifier
// Flags letters, URL bytes, ':' and '/' for the scan core.
// ----------------------------------------------------------------------------
module uss_byte_class (
    input  logic [7:0]           i_text_byte,
    output uss_pkg::t_byte_class o_class
);
    import uss_pkg::*;

    logic letter;
    logic digit;
    logic punct;

    always_comb begin
        letter = (i_text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        digit  = (i_text_byte inside {[8'h30:8'h39]});
        // ~ ; / ? : @ = & $ - _ . + ! * ( ) , ' and the quote bytes E2 80 99
        punct  = (i_text_byte inside {8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40,
                                      8'h3D, 8'h26, 8'h24, 8'h2D, 8'h5F, 8'h2E,
                                      8'h2B, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C,
                                      8'h27, 8'hE2, 8'h80, 8'h99});
        o_class.is_letter = letter;
        o_class.is_url    = letter | digit | punct;
        o_class.is_colon  = (i_text_byte == 8'h3A);
        o_class.is_slash  = (i_text_byte == 8'h2F);
    end

endmodule

[hdl/uss_scan_core.sv]
// ----------------------------------------------------------------------------
// uss_scan_core - running scan state and URL span decision
// Updates the per-line state for one byte and builds the result record.
// ----------------------------------------------------------------------------
module uss_scan_core #(
    parameter int MaxLineBytes = uss_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_line_end,
    input  uss_pkg::t_byte_class i_class,
    output uss_pkg::t_result     o_result
);
    import uss_pkg::*;

    localparam int OffW = $clog2(MaxLineBytes + 1);
    localparam logic [OffW-1:0] MaxOff = OffW'(MaxLineBytes);

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_COLON,
        SEP_SLASH
    } t_sep_phase;

    logic [OffW-1:0] r_byte_offset,    n_byte_offset;
    logic [OffW-1:0] r_run_start,      n_run_start;
    logic            r_run_active,     n_run_active;
    t_sep_phase      r_sep_phase,      n_sep_phase;
    logic [OffW-1:0] r_cand_start,     n_cand_start;
    logic            r_cand_valid,     n_cand_valid;
    logic            r_url_open,       n_url_open;
    logic [OffW-1:0] r_open_start,     n_open_start;
    logic            r_overflow,       n_overflow;

    logic [OffW-1:0] pos_next;
    logic            at_max;

    always_comb begin
        at_max   = (r_byte_offset >= MaxOff);
        pos_next = at_max ? MaxOff : r_byte_offset + 1'b1;

        n_byte_offset = pos_next;
        n_run_start   = r_run_start;
        n_run_active  = r_run_active;
        n_sep_phase   = r_sep_phase;
        n_cand_start  = r_cand_start;
        n_cand_valid  = 1'b0;        // a pending separator is checked by this byte
        n_url_open    = r_url_open;
        n_open_start  = r_open_start;
        n_overflow    = r_overflow | at_max;

        o_result.emit             = 1'b0;
        o_result.url_start        = OUT_W'(n_open_start);
        o_result.url_stop         = OUT_W'(r_byte_offset);
        o_result.offset_saturated = n_overflow;

        if (r_cand_valid && i_class.is_url) begin
            n_url_open   = 1'b1;
            n_open_start = r_cand_start;
        end
        o_result.url_start = OUT_W'(n_open_start);

        if (n_url_open) begin
            if (!i_class.is_url) begin
                o_result.emit = 1'b1;
                n_url_open    = 1'b0;
                n_run_active  = 1'b0;
                n_sep_phase   = SEP_NONE;
            end else if (i_line_end) begin
                o_result.emit     = 1'b1;
                o_result.url_stop = OUT_W'(pos_next);
            end
        end else begin
            if (i_class.is_colon) begin
                n_sep_phase = r_run_active ? SEP_COLON : SEP_NONE;
            end else if (i_class.is_slash && r_sep_phase == SEP_COLON) begin
                n_sep_phase = SEP_SLASH;
            end else if (i_class.is_slash && r_sep_phase == SEP_SLASH) begin
                n_sep_phase  = SEP_NONE;
                n_cand_valid = 1'b1;
                n_cand_start = r_run_start;
            end else begin
                n_sep_phase = SEP_NONE;
            end
            if (i_class.is_letter) begin
                if (!r_run_active) begin
                    n_run_start = r_byte_offset;
                end
                n_run_active = 1'b1;
            end else begin
                n_run_active = 1'b0;
            end
        end

        // end of line: back to a clean state
        if (i_line_end) begin
            n_byte_offset = '0;
            n_run_start   = '0;
            n_run_active  = 1'b0;
            n_sep_phase   = SEP_NONE;
            n_cand_start  = '0;
            n_cand_valid  = 1'b0;
            n_url_open    = 1'b0;
            n_open_start  = '0;
            n_overflow    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_run_start   <= '0;
            r_run_active  <= 1'b0;
            r_sep_phase   <= SEP_NONE;
            r_cand_start  <= '0;
            r_cand_valid  <= 1'b0;
            r_url_open    <= 1'b0;
            r_open_start  <= '0;
            r_overflow    <= 1'b0;
        end else if (i_en) begin
            r_byte_offset <= n_byte_offset;
            r_run_start   <= n_run_start;
            r_run_active  <= n_run_active;
            r_sep_phase   <= n_sep_phase;
            r_cand_start  <= n_cand_start;
            r_cand_valid  <= n_cand_valid;
            r_url_open    <= n_url_open;
            r_open_start  <= n_open_start;
            r_overflow    <= n_overflow;
        end
    end

endmodule

[hdl/uss_checker.sv]
// ----------------------------------------------------------------------------
// uss_checker - port-level checks for the URL span scanner
// Watches the top-level ports; bound to url_span_scanner_top.
// ----------------------------------------------------------------------------
module uss_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [uss_pkg::OUT_W-1:0] o_url_start,
    input logic [uss_pkg::OUT_W-1:0] o_url_stop,
    input logic                      o_offset_saturated
);
    import uss_pkg::*;

    // no result straight out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_url_start) && $stable(o_url_stop)
            && $stable(o_offset_saturated))
        else $error("stalled result changed");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // a URL never ends before it starts
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_url_start <= o_url_stop)
        else $error("url_stop before url_start");

endmodule

bind url_span_scanner_top uss_checker u_uss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_url_start        (o_url_start),
    .o_url_stop         (o_url_stop),
    .o_offset_saturated (o_offset_saturated)
);
